### rtl/cosine_match_gallery_update_unit_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef COSINE_MATCH_GALLERY_UPDATE_UNIT_MACROS_SVH
`define COSINE_MATCH_GALLERY_UPDATE_UNIT_MACROS_SVH

`ifndef SYNTH
`define CMG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CMG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMG_ASSERT(label, prop, msg)
`define CMG_ASSERT_IMP(label, ante, cons, msg)
`define CMG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/cmg_pkg.sv
`default_nettype none
package cmg_pkg;

    localparam int GALLERY_ENTRIES = 64;
    localparam int VECTOR_LENGTH   = 256;
    localparam int ELEMENT_BITS    = 16;

    localparam int ENTRY_W  = $clog2(GALLERY_ENTRIES);
    localparam int COUNT_W  = $clog2(GALLERY_ENTRIES + 1);
    localparam int ADDR_W   = $clog2(VECTOR_LENGTH);
    localparam int POS_W    = $clog2(VECTOR_LENGTH + 1);
    localparam int GADDR_W  = ENTRY_W + ADDR_W;
    localparam int SQ_W     = 2 * ELEMENT_BITS - 1;
    localparam int PROD_W   = 2 * ELEMENT_BITS;
    localparam int NORM_W   = SQ_W + ADDR_W;
    localparam int ROOT_W   = (NORM_W + 1) / 2;
    localparam int RES_W    = NORM_W + 1;
    localparam int DOT_W    = NORM_W + 1;
    localparam int DEN_W    = 2 * ROOT_W;
    localparam int REM_W    = DEN_W + 1;
    localparam int SIM_W    = 16;
    localparam int Q_W      = SIM_W - 1;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [SIM_W-1:0] ONE_Q15       = 16'h8000;
    localparam logic [SIM_W-1:0] THRESH_RESET  = 16'h4000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic [POS_W-1:0]  len;
    } job_t;

endpackage
`default_nettype wire

### rtl/cmg_front.sv
`default_nettype none
module cmg_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [cmg_pkg::ELEMENT_BITS-1:0] element,
    input  logic                                    last,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output logic                                    job_push,
    output cmg_pkg::job_t                           job,
    input  logic                                    release_buf,
    input  logic [cmg_pkg::ADDR_W-1:0]              rd_addr,
    output logic signed [cmg_pkg::ELEMENT_BITS-1:0] rd_data
);
    import cmg_pkg::*;

    logic signed [ELEMENT_BITS-1:0] vec_mem [VECTOR_LENGTH];
    logic signed [ELEMENT_BITS-1:0] rd_data_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              sq_v_reg;
    logic              last_d_reg;
    logic              busy_reg;

    logic                    accept;
    logic                    in_range;
    logic signed [PROD_W-1:0] sq_full;
    logic [NORM_W-1:0]       norm_sum;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign in_range = pos_reg < POS_W'(VECTOR_LENGTH);
    assign sq_full  = element * element;
    assign norm_sum = norm_reg + (sq_v_reg ? NORM_W'(sq_reg) : '0);

    // square is registered, so the finished norm is pushed in the cycle after last
    assign job_push = last_d_reg;
    assign job.norm = norm_sum;
    assign job.len  = pos_reg;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            vec_mem[pos_reg[ADDR_W-1:0]] <= element;
        end
        rd_data_reg <= vec_mem[rd_addr];
        sq_reg      <= sq_full[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            norm_reg   <= '0;
            sq_v_reg   <= 1'b0;
            last_d_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            sq_v_reg   <= accept && in_range;
            last_d_reg <= accept && last;
            if (last_d_reg)
            begin
                norm_reg <= '0;
                pos_reg  <= '0;
            end
            else
            begin
                norm_reg <= norm_sum;
                if (accept && in_range)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (accept && last)
            begin
                busy_reg <= 1'b1;
            end
            else if (release_buf)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/cmg_job_fifo.sv
`default_nettype none
module cmg_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmg_pkg::job_t din,
    input  logic          pop,
    output cmg_pkg::job_t dout,
    output logic          empty,
    output logic          full
);
    import cmg_pkg::*;

    job_t                  slots [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   fill_reg;
    logic                  do_push;
    logic                  do_pop;

    assign empty   = fill_reg == '0;
    assign full    = fill_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (FIFO_PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (FIFO_PTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/cmg_isqrt.sv
`default_nettype none
module cmg_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cmg_pkg::NORM_W-1:0]  radicand,
    output logic                        done,
    output logic [cmg_pkg::ROOT_W-1:0]  root
);
    import cmg_pkg::*;

    localparam logic [RES_W-1:0] BIT_INIT = RES_W'(1) << (2 * (ROOT_W - 1));

    logic [NORM_W-1:0] v_reg;
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  bit_reg;
    logic              active_reg;
    logic              done_reg;
    logic [RES_W-1:0]  trial;

    // restoring square root, one result bit per cycle
    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= BIT_INIT;
        end
        else if (active_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg   <= v_reg - trial[NORM_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
            end
            else if (active_reg && (bit_reg >> 2) == '0)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/cmg_back.sv
`default_nettype none
`include "cosine_match_gallery_update_unit_macros.svh"
module cmg_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [cmg_pkg::SIM_W-1:0]               threshold,
    input  logic                                    job_valid,
    input  cmg_pkg::job_t                           job,
    output logic                                    job_pop,
    output logic                                    release_buf,
    output logic [cmg_pkg::ADDR_W-1:0]              vec_rd_addr,
    input  logic signed [cmg_pkg::ELEMENT_BITS-1:0] vec_rd_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [cmg_pkg::ENTRY_W-1:0]             entry_index,
    output logic                                    is_new,
    output logic [cmg_pkg::SIM_W-1:0]               best_similarity,
    output cmg_pkg::status_t                        status
);
    import cmg_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_ROOT    = 11'b00000000010,
        S_ENTRY   = 11'b00000000100,
        S_DOT     = 11'b00000001000,
        S_DEN     = 11'b00000010000,
        S_DIVSET  = 11'b00000100000,
        S_DIV     = 11'b00001000000,
        S_CMP     = 11'b00010000000,
        S_DECIDE  = 11'b00100000000,
        S_COPY    = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic signed [ELEMENT_BITS-1:0] gallery_mem [GALLERY_ENTRIES * VECTOR_LENGTH];
    logic [ROOT_W-1:0]              root_mem [GALLERY_ENTRIES];
    logic signed [ELEMENT_BITS-1:0] g_rd_reg;
    logic [ROOT_W-1:0]              root_rd_reg;

    logic [POS_W-1:0]   len_reg;
    logic [ROOT_W-1:0]  in_root_reg;
    logic [COUNT_W-1:0] k_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SIM_W-1:0]   best_sim_reg;
    logic [ENTRY_W-1:0] best_ind_reg;
    logic [POS_W-1:0]   cnt_reg;
    logic               rd_v_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic               rd_mask_reg;
    logic               prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]  acc_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [Q_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SIM_W-1:0]   sim_reg;
    logic [ENTRY_W-1:0] dst_reg;
    logic [ENTRY_W-1:0] res_index_reg;
    logic               res_new_reg;
    status_t            res_status_reg;

    logic               out_valid_reg;
    logic [ENTRY_W-1:0] out_index_reg;
    logic               out_new_reg;
    logic [SIM_W-1:0]   out_sim_reg;
    status_t            out_status_reg;

    logic               root_start;
    logic               root_done;
    logic [ROOT_W-1:0]  root_val;

    logic               issue;
    logic               g_we;
    logic [ENTRY_W-1:0] decide_dst;
    logic               decide_store;
    logic               out_load;
    logic               dot_done;
    logic               copy_done;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   den_ext;
    logic [REM_W-1:0]   dot_ext;
    logic [Q_W-1:0]     q_next;
    logic signed [PROD_W-1:0] prod_full;

    cmg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (job.norm),
        .done     (root_done),
        .root     (root_val)
    );

    assign issue       = (state_reg == S_DOT || state_reg == S_COPY)
                         && cnt_reg < POS_W'(VECTOR_LENGTH);
    assign vec_rd_addr = cnt_reg[ADDR_W-1:0];
    assign g_we        = state_reg == S_COPY && rd_v_reg;
    assign prod_full   = g_rd_reg * vec_rd_data;
    assign dot_done    = cnt_reg == POS_W'(VECTOR_LENGTH) && !rd_v_reg && !prod_v_reg;
    assign copy_done   = cnt_reg == POS_W'(VECTOR_LENGTH) && !rd_v_reg;
    assign out_load    = state_reg == S_OUT && (!out_valid_reg || out_ready);
    assign release_buf = out_load;
    assign job_pop     = state_reg == S_IDLE && job_valid;
    assign root_start  = job_pop && job.norm != '0;

    assign den_ext   = REM_W'(den_reg);
    assign dot_ext   = REM_W'($unsigned(acc_reg));
    assign rem_shift = {rem_reg[REM_W-2:0], 1'b0};
    assign q_next    = {q_reg[Q_W-2:0], rem_shift >= den_ext};

    // reuse the best entry only when it clears the threshold
    assign decide_store = (best_sim_reg > threshold)
                          || count_reg < COUNT_W'(GALLERY_ENTRIES);
    assign decide_dst   = (best_sim_reg > threshold) ? best_ind_reg
                          : count_reg[ENTRY_W-1:0];

    assign out_valid       = out_valid_reg;
    assign entry_index     = out_index_reg;
    assign is_new          = out_new_reg;
    assign best_similarity = out_sim_reg;
    assign status          = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gallery_mem[{dst_reg, rd_idx_reg}] <= rd_mask_reg ? vec_rd_data : '0;
        end
        g_rd_reg <= gallery_mem[{k_reg[ENTRY_W-1:0], cnt_reg[ADDR_W-1:0]}];
        if (state_reg == S_DECIDE && decide_store)
        begin
            root_mem[decide_dst] <= in_root_reg;
        end
        root_rd_reg <= root_mem[k_reg[ENTRY_W-1:0]];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= cnt_reg[ADDR_W-1:0];
        rd_mask_reg <= cnt_reg < len_reg;
        prod_reg    <= rd_mask_reg ? prod_full : '0;
        if (state_reg == S_ENTRY)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + DOT_W'(prod_reg);
        end
        if (state_reg == S_DEN)
        begin
            den_reg <= DEN_W'(in_root_reg) * DEN_W'(root_rd_reg);
        end
        if (state_reg == S_DIVSET)
        begin
            rem_reg <= dot_ext;
            q_reg   <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= (rem_shift >= den_ext) ? rem_shift - den_ext : rem_shift;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            in_root_reg    <= '0;
            k_reg          <= '0;
            count_reg      <= '0;
            best_sim_reg   <= '0;
            best_ind_reg   <= '0;
            cnt_reg        <= '0;
            rd_v_reg       <= 1'b0;
            prod_v_reg     <= 1'b0;
            div_cnt_reg    <= '0;
            sim_reg        <= '0;
            dst_reg        <= '0;
            res_index_reg  <= '0;
            res_new_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_new_reg    <= 1'b0;
            out_sim_reg    <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg && state_reg == S_DOT;
            if (issue)
            begin
                cnt_reg <= cnt_reg + POS_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_index_reg  <= res_index_reg;
                out_new_reg    <= res_new_reg;
                out_sim_reg    <= best_sim_reg;
                out_status_reg <= res_status_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        len_reg      <= job.len;
                        best_sim_reg <= '0;
                        best_ind_reg <= '0;
                        k_reg        <= '0;
                        if (job.norm == '0)
                        begin
                            res_index_reg  <= '0;
                            res_new_reg    <= 1'b0;
                            res_status_reg <= ST_ZERO;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        in_root_reg <= root_val;
                        state_reg   <= (count_reg == '0) ? S_DECIDE : S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DOT;
                end
                S_DOT:
                begin
                    if (dot_done)
                    begin
                        if (acc_reg > 0)
                        begin
                            state_reg <= S_DEN;
                        end
                        else
                        begin
                            sim_reg   <= '0;
                            state_reg <= S_CMP;
                        end
                    end
                end
                S_DEN:
                begin
                    state_reg <= S_DIVSET;
                end
                S_DIVSET:
                begin
                    div_cnt_reg <= '0;
                    if (den_reg == '0)
                    begin
                        sim_reg   <= '0;
                        state_reg <= S_CMP;
                    end
                    else if (dot_ext >= den_ext)
                    begin
                        sim_reg   <= ONE_Q15;
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        sim_reg   <= {1'b0, q_next};
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    // strict compare keeps the lower index on a tie
                    if (sim_reg > best_sim_reg)
                    begin
                        best_sim_reg <= sim_reg;
                        best_ind_reg <= k_reg[ENTRY_W-1:0];
                    end
                    k_reg <= k_reg + COUNT_W'(1);
                    state_reg <= (k_reg + COUNT_W'(1) == count_reg) ? S_DECIDE : S_ENTRY;
                end
                S_DECIDE:
                begin
                    dst_reg <= decide_dst;
                    cnt_reg <= '0;
                    if (best_sim_reg > threshold)
                    begin
                        res_index_reg  <= best_ind_reg;
                        res_new_reg    <= 1'b0;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_COPY;
                    end
                    else if (decide_store)
                    begin
                        res_index_reg  <= count_reg[ENTRY_W-1:0];
                        res_new_reg    <= 1'b1;
                        res_status_reg <= ST_OK;
                        count_reg      <= count_reg + COUNT_W'(1);
                        state_reg      <= S_COPY;
                    end
                    else
                    begin
                        res_index_reg  <= '0;
                        res_new_reg    <= 1'b0;
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_OUT;
                    end
                end
                S_COPY:
                begin
                    if (copy_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CMG_ASSERT(a_count_bound, count_reg <= COUNT_W'(GALLERY_ENTRIES), "entry count overflow")
    `CMG_ASSERT(a_best_bound, best_sim_reg <= ONE_Q15, "best similarity above one")
    `CMG_ASSERT_IMP(a_zero_clean, out_valid_reg && out_status_reg == ST_ZERO, out_index_reg == '0 && !out_new_reg && out_sim_reg == '0, "zero vector result not cleared")
    `CMG_ASSERT_NEXT(a_release_out, release_buf, out_valid_reg, "buffer released without result")

endmodule
`default_nettype wire

### rtl/cosine_match_gallery_update_unit.sv
`default_nettype none
`include "cosine_match_gallery_update_unit_macros.svh"
// Cosine-similarity gallery matcher.
// Input channel (in_valid/in_ready): one signed Q4.12 element per request,
// last marks the end of a vector. Elements past 256 are dropped, a short
// vector is zero padded. Config channel (cfg_valid/cfg_ready) writes
// match_threshold; always ready, write only while idle.
// Output channel (out_valid/out_ready): one result per vector with the
// entry index, new-entry flag, best similarity (Q1.15) and status.
// Work per vector after last: the norm root, then per stored entry a dot
// product (one element per cycle through the gallery memory read port)
// plus a divide where needed, then a copy of the vector into the gallery
// unless the gallery is full and nothing matched.
// Elements stream in one per cycle while no vector is in flight; the input
// stalls from last until the result is registered.
// Reset empties the gallery and sets the threshold to 0.5. A stalled
// receiver holds the result register and the next vector waits behind it.
module cosine_match_gallery_update_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [cmg_pkg::ELEMENT_BITS-1:0] element,
    input  logic                                    last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cmg_pkg::SIM_W-1:0]               match_threshold,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [cmg_pkg::ENTRY_W-1:0]             entry_index,
    output logic                                    is_new,
    output logic [cmg_pkg::SIM_W-1:0]               best_similarity,
    output logic [1:0]                              status
);
    import cmg_pkg::*;

    logic [SIM_W-1:0] thresh_reg;
    logic             job_push;
    job_t             job_in;
    job_t             job_head;
    logic             job_empty;
    logic             job_full;
    logic             job_pop;
    logic             release_buf;
    logic [ADDR_W-1:0] vec_rd_addr;
    logic signed [ELEMENT_BITS-1:0] vec_rd_data;
    status_t          status_w;

    assign cfg_ready = 1'b1;
    assign status    = status_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= match_threshold;
        end
    end

    cmg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .element     (element),
        .last        (last),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .job_push    (job_push),
        .job         (job_in),
        .release_buf (release_buf),
        .rd_addr     (vec_rd_addr),
        .rd_data     (vec_rd_data)
    );

    cmg_job_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .dout  (job_head),
        .empty (job_empty),
        .full  (job_full)
    );

    cmg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold       (thresh_reg),
        .job_valid       (!job_empty),
        .job             (job_head),
        .job_pop         (job_pop),
        .release_buf     (release_buf),
        .vec_rd_addr     (vec_rd_addr),
        .vec_rd_data     (vec_rd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .entry_index     (entry_index),
        .is_new          (is_new),
        .best_similarity (best_similarity),
        .status          (status_w)
    );

    `CMG_ASSERT_IMP(a_push_room, job_push, !job_full, "job pushed into full queue")
    `CMG_ASSERT_IMP(a_front_held, !job_empty, !in_ready, "input open while a vector is queued")
    `CMG_ASSERT_NEXT(a_pop_stalls, job_pop, !in_ready, "front reopened on pop")

endmodule
`default_nettype wire
